>>> src/pvc_pkg.sv
// Shared constants for the PID velocity controller.
// Widths of the shared multiplier and of the divider, register indexes and reset values.
// No dependencies.
package pvc_pkg;

  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

  localparam logic [15:0] GAIN_P_RESET = 16'd256;
  localparam logic [23:0] PERIOD_RESET = 24'd5592;

endpackage

>>> src/pvc_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on pvc_pkg for operand widths.
module pvc_mul (
  input  logic                       clk,
  input  logic [pvc_pkg::MUL_W-1:0]  a,
  input  logic [pvc_pkg::MUL_W-1:0]  b,
  output logic [pvc_pkg::PROD_W-1:0] prod
);
  import pvc_pkg::*;

  logic [PROD_W-1:0] a_ext;
  logic [PROD_W-1:0] b_ext;

  assign a_ext = {{(PROD_W-MUL_W){1'b0}}, a};
  assign b_ext = {{(PROD_W-MUL_W){1'b0}}, b};

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
  end

endmodule

>>> src/pvc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pvc_pkg for dividend, divisor and counter widths.
module pvc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pvc_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [pvc_pkg::DIV_DEN_W-1:0] divisor,
  output logic                          busy,
  output logic [pvc_pkg::DIV_NUM_W-1:0] quotient
);
  import pvc_pkg::*;

  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = quo;

endmodule

>>> src/pid_velocity_controller_top.sv
// PID velocity controller: sequencer, state and config registers around a shared
// multiplier (pvc_mul) and a bit-serial divider (pvc_div). Depends on pvc_pkg.
// A compute item runs from input to result transfer in a time set by the divider's 50
// single-bit steps; a clear item goes straight to its result. One item at a time.
// Reset (rst, synchronous) clears the integral sum, previous error and out_valid,
// and loads gain_p = 1.0, gain_i = gain_d = 0, sample_period = 5592.
module pid_velocity_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic signed [15:0]             command,
  input  logic signed [15:0]             measured,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             drive
);
  import pvc_pkg::*;

  localparam int ACC_W = 53;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_M_D      = 4'd2;
  localparam logic [3:0] S_M_P      = 4'd3;
  localparam logic [3:0] S_M_K      = 4'd4;
  localparam logic [3:0] S_M_LO     = 4'd5;
  localparam logic [3:0] S_M_HI     = 4'd6;
  localparam logic [3:0] S_I_SUM    = 4'd7;
  localparam logic [3:0] S_I_ACC    = 4'd8;
  localparam logic [3:0] S_WAIT_DIV = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]  state;
  logic [3:0]  state_next;

  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [23:0] sample_period;

  logic [31:0] error_sum;
  logic [16:0] previous_error;
  logic [16:0] err;

  logic [15:0] e_mag;
  logic        e_neg;
  logic [31:0] s_mag;
  logic        s_neg;
  logic [17:0] de_mag;
  logic        de_neg;

  logic [19:0] kt_hi;
  logic [31:0] lo_sh;
  logic [52:0] isum;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;

  logic [32:0] sum_ext;
  logic [31:0] sum_sat;
  logic [17:0] de_ext;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;
  logic                 div_start;
  logic                 div_busy;
  logic [DIV_NUM_W-1:0] quotient;

  logic [DIV_NUM_W-1:0] term_mag;
  logic                 term_neg;
  logic [ACC_W-1:0]     term_ext;

  logic        in_xfer;
  logic        out_load;
  logic [31:0] drive_sat;

  assign in_ready = state == S_IDLE;
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= GAIN_P_RESET;
      gain_i        <= '0;
      gain_d        <= '0;
      sample_period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_P:
          gain_p <= (cfg_data[15:0] == '0) ? GAIN_P_RESET : cfg_data[15:0];
        REG_GAIN_I:
          gain_i <= cfg_data[15:0];
        REG_GAIN_D:
          gain_d <= cfg_data[15:0];
        REG_SAMPLE_PERIOD:
          sample_period <= (cfg_data == '0) ? 24'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // integral update and error difference
  assign sum_ext = {error_sum[31], error_sum} + {{16{err[16]}}, err};
  assign de_ext  = {err[16], err} - {previous_error[16], previous_error};

  always_comb begin
    if (sum_ext[32] != sum_ext[31]) begin
      sum_sat = sum_ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sum_sat = sum_ext[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_xfer) state_next = mode ? S_DONE : S_PREP;
      S_PREP:     state_next = S_M_D;
      S_M_D:      state_next = S_M_P;
      S_M_P:      state_next = S_M_K;
      S_M_K:      state_next = S_M_LO;
      S_M_LO:     state_next = S_M_HI;
      S_M_HI:     state_next = S_I_SUM;
      S_I_SUM:    state_next = S_I_ACC;
      S_I_ACC:    state_next = S_WAIT_DIV;
      S_WAIT_DIV: if (!div_busy) state_next = S_DONE;
      S_DONE:     if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M_D: begin
        mul_a = {16'b0, gain_d};
        mul_b = {14'b0, de_mag};
      end
      S_M_P: begin
        mul_a = {16'b0, gain_p};
        mul_b = {16'b0, e_mag};
      end
      S_M_K: begin
        mul_a = {16'b0, gain_i};
        mul_b = {8'b0, sample_period};
      end
      S_M_LO: begin
        mul_a = {12'b0, prod[19:0]};
        mul_b = s_mag;
      end
      S_M_HI: begin
        mul_a = {12'b0, kt_hi};
        mul_b = s_mag;
      end
      default: ;
    endcase
  end

  pvc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_start = state == S_M_P;

  pvc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({prod[33:0], 16'b0}),
    .divisor  (sample_period),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // signed accumulate of P, I and D magnitudes
  always_comb begin
    term_mag = '0;
    term_neg = 1'b0;
    unique case (state)
      S_M_K: begin
        term_mag = {26'b0, prod[31:8]};
        term_neg = e_neg;
      end
      S_I_ACC: begin
        term_mag = {10'b0, isum[52:13]};
        term_neg = s_neg;
      end
      S_WAIT_DIV: begin
        term_mag = quotient;
        term_neg = de_neg;
      end
      default: ;
    endcase
  end

  assign term_ext = {{(ACC_W-DIV_NUM_W){1'b0}}, term_mag};
  assign acc_next = term_neg ? acc - term_ext : acc + term_ext;

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err <= {command[15], command} - {measured[15], measured};
      acc <= '0;
    end
    if (state == S_PREP) begin
      e_neg  <= err[16];
      e_mag  <= err[16] ? 16'(17'd0 - err) : err[15:0];
      s_neg  <= sum_sat[31];
      s_mag  <= sum_sat[31] ? 32'd0 - sum_sat : sum_sat;
      de_neg <= de_ext[17];
      de_mag <= de_ext[17] ? 18'd0 - de_ext : de_ext;
    end
    if (state == S_M_LO) begin
      kt_hi <= prod[39:20];
    end
    if (state == S_M_HI) begin
      lo_sh <= prod[51:20];
    end
    if (state == S_I_SUM) begin
      isum <= {1'b0, prod[51:0]} + {21'b0, lo_sh};
    end
    if (state == S_M_K || state == S_I_ACC || (state == S_WAIT_DIV && !div_busy)) begin
      acc <= acc_next;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (in_xfer && mode) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (state == S_PREP) begin
      error_sum      <= sum_sat;
      previous_error <= err;
    end
  end

  // output saturation and register
  always_comb begin
    if (acc[ACC_W-1] && !(&acc[ACC_W-1:31])) begin
      drive_sat = 32'h8000_0000;
    end else if (!acc[ACC_W-1] && (|acc[ACC_W-2:31])) begin
      drive_sat = 32'h7FFF_FFFF;
    end else begin
      drive_sat = acc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive <= drive_sat;
    end
  end

endmodule
